[rtl/bew_pkg.sv]
// Package for the boid Euler integration step.
// Constants and the register index codes shared by the modules; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bew_pkg;

  localparam int unsigned NUM_STEER   = 6;
  localparam int unsigned WEIGHT_BITS = 10;
  localparam int unsigned WEIGHT_FRAC = 8;
  localparam int unsigned STEP_FRAC   = 16;
  localparam int unsigned REG_BITS    = 16;
  localparam int unsigned QUOT_BITS   = 17;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam logic [REG_BITS-1:0] MAX_SPEED_RST = 16'h0100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WEIGHTS   = 3'd0,
    CFG_MAX_SPEED = 3'd1,
    CFG_ANG_RATE  = 3'd2,
    CFG_TIME_STEP = 3'd3,
    CFG_BOUND_HI  = 3'd4,
    CFG_BOUND_LO  = 3'd5,
    CFG_FLAT      = 3'd6
  } cfg_idx_e;

endpackage
`default_nettype wire

[rtl/boid_euler_integration_step.sv]
// Boid Euler integration step: one boid per transaction in, one updated boid out.
// The datapath is a single pipeline that takes a new boid every clock cycle unless the
// output is stalled: four steering stages, one square-root stage per bit of the widened
// speed (COMPONENT_BITS + 4), one numerator stage, 17 divider stages for the speed clamp,
// three rotation and integration stages and the output register.
// The whole pipeline advances whenever the output register is empty or being taken, so a
// stall on the master side holds every stage in place. Configuration is taken every cycle
// and should only be written while no boid is in flight.
// Uses bew_pkg, bew_steer, bew_sqrt and bew_div.
`timescale 1ns / 1ps
`default_nettype none
module boid_euler_integration_step import bew_pkg::*; #(
  parameter int unsigned COMPONENT_BITS = 16,
  parameter int unsigned FRACTION_BITS  = 8
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // position, velocity, separation_vec, alignment_vec, cohesion_vec, goal_vec, avoid_vec,
  // wander_vec
  input  wire logic [((24*COMPONENT_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  wire logic s_axis_tlast,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // new_position, new_velocity
  output logic [((6*COMPONENT_BITS+7)/8)*8-1:0] m_axis_tdata,
  output logic      m_axis_tlast,
  input  wire logic cfg_valid_i,
  output logic      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned C    = COMPONENT_BITS;
  localparam int unsigned F    = FRACTION_BITS;
  localparam int unsigned W    = C + 4;
  localparam int unsigned VB   = 3 * C;
  localparam int unsigned OUT_W = ((6*C+7)/8)*8;
  localparam int unsigned NW   = W + 18;
  localparam int unsigned DW   = W + 1;
  localparam int unsigned QW   = QUOT_BITS;
  localparam int unsigned VW   = (W > QW + 1) ? W : QW + 1;
  localparam int unsigned PM   = C + REG_BITS;
  localparam int unsigned RV   = C + 18;
  localparam int unsigned XW   = C + 18;
  localparam int unsigned SW   = 2 + VB + 3 * W;
  localparam logic signed [PM:0]   RHALF = (PM+1)'(1) << (F - 1);
  localparam logic signed [XW-1:0] SHALF = XW'(1) << (STEP_FRAC - 1);

  logic [NUM_STEER*WEIGHT_BITS-1:0] weights_q;
  logic [REG_BITS-1:0] max_speed_q, ang_q, ts_q;
  logic [VB-1:0]       bhi_q, blo_q;
  logic                flat_q;
  logic                en;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weights_q   <= '0;
      max_speed_q <= REG_BITS'(1) << F;
      ang_q       <= '0;
      ts_q        <= '0;
      bhi_q       <= '0;
      blo_q       <= '0;
      flat_q      <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_WEIGHTS:   weights_q   <= cfg_data_i[NUM_STEER*WEIGHT_BITS-1:0];
        CFG_MAX_SPEED: max_speed_q <= cfg_data_i[REG_BITS-1:0];
        CFG_ANG_RATE:  ang_q       <= cfg_data_i[REG_BITS-1:0];
        CFG_TIME_STEP: ts_q        <= cfg_data_i[REG_BITS-1:0];
        CFG_BOUND_HI:  bhi_q       <= cfg_data_i[VB-1:0];
        CFG_BOUND_LO:  blo_q       <= cfg_data_i[VB-1:0];
        CFG_FLAT:      flat_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic out_vld_q;
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // steering
  logic            st_vld, st_last, st_clamp;
  logic [VB-1:0]   st_pos;
  logic [3*W-1:0]  st_vel;
  logic [2*W-1:0]  st_mag2;

  bew_steer #(.C(C)) u_steer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (s_axis_tvalid),
    .position_i (s_axis_tdata[0 +: VB]),
    .velocity_i (s_axis_tdata[VB +: VB]),
    .steer_i    (s_axis_tdata[2*VB +: NUM_STEER*VB]),
    .last_i     (s_axis_tlast),
    .weights_i  (weights_q),
    .max_speed_i(max_speed_q),
    .valid_o    (st_vld),
    .position_o (st_pos),
    .velocity_o (st_vel),
    .last_o     (st_last),
    .mag2_o     (st_mag2),
    .clamp_o    (st_clamp)
  );

  // magnitude
  logic            sq_vld;
  logic [W-1:0]    sq_root;
  logic [SW-1:0]   sq_side;

  bew_sqrt #(.RW(W), .SW(SW)) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(st_vld),
    .rad_i  (st_mag2),
    .side_i ({st_last, st_clamp, st_pos, st_vel}),
    .valid_o(sq_vld),
    .root_o (sq_root),
    .side_o (sq_side)
  );

  // clamp numerators
  logic            nm_vld_q;
  logic [3*NW-1:0] num_d, num_q;
  logic [DW-1:0]   den_q;
  logic [SW-1:0]   nm_side_q;

  always_comb begin
    logic [W-1:0]    a;
    logic [W+15:0]   am;
    logic signed [W-1:0] vk;
    for (int k = 0; k < 3; k++) begin
      vk = $signed(sq_side[k*W +: W]);
      a  = vk[W-1] ? W'(-vk) : W'(vk);
      am = a * max_speed_q;
      num_d[k*NW +: NW] = {1'b0, am, 1'b0} + NW'(sq_root);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nm_vld_q <= 1'b0;
    end else if (en) begin
      nm_vld_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q     <= num_d;
      den_q     <= {sq_root, 1'b0};
      nm_side_q <= sq_side;
    end
  end

  logic            dv_vld;
  logic [3*QW-1:0] dv_quot;
  logic [SW-1:0]   dv_side;

  bew_div #(.NW(NW), .DW(DW), .QW(QW), .SW(SW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(nm_vld_q),
    .num_i  (num_q),
    .den_i  (den_q),
    .side_i (nm_side_q),
    .valid_o(dv_vld),
    .quot_o (dv_quot),
    .side_o (dv_side)
  );

  logic            dv_last, dv_clamp;
  logic [VB-1:0]   dv_pos;
  logic [3*W-1:0]  dv_vel;
  assign {dv_last, dv_clamp, dv_pos, dv_vel} = dv_side;

  // clamp select and rotation products
  logic                 r1_vld_q, r1_last_q;
  logic [VB-1:0]        r1_pos_q;
  logic signed [VW-1:0] vc_d [3];
  logic signed [VW-1:0] vc_q [3];
  logic signed [PM-1:0] pm0_q, pm1_q;

  always_comb begin
    logic signed [VW-1:0] q;
    for (int k = 0; k < 3; k++) begin
      q = VW'({1'b0, dv_quot[k*QW +: QW]});
      if (dv_clamp) begin
        vc_d[k] = dv_vel[k*W + W - 1] ? -q : q;
      end else begin
        vc_d[k] = VW'($signed(dv_vel[k*W +: W]));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_vld_q <= 1'b0;
    end else if (en) begin
      r1_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vc_q      <= vc_d;
      pm0_q     <= $signed(dv_pos[C +: C]) * $signed(ang_q);
      pm1_q     <= $signed(dv_pos[0 +: C]) * $signed(ang_q);
      r1_pos_q  <= dv_pos;
      r1_last_q <= dv_last;
    end
  end

  // rotation add and saturation
  logic              r2_vld_q, r2_last_q;
  logic [VB-1:0]     r2_pos_q;
  logic [VB-1:0]     vs_d, vs_q;

  always_comb begin
    logic signed [PM:0]   rr0, rr1;
    logic signed [RV-1:0] vr [3];
    rr0   = ((PM+1)'(pm0_q) + RHALF) >>> F;
    rr1   = ((PM+1)'(pm1_q) + RHALF) >>> F;
    vr[0] = RV'(vc_q[0]) - RV'(rr0);
    vr[1] = RV'(vc_q[1]) + RV'(rr1);
    vr[2] = RV'(vc_q[2]);
    for (int k = 0; k < 3; k++) begin
      if (&vr[k][RV-1:C-1] || ~|vr[k][RV-1:C-1]) begin
        vs_d[k*C +: C] = vr[k][C-1:0];
      end else begin
        vs_d[k*C +: C] = vr[k][RV-1] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r2_vld_q <= 1'b0;
    end else if (en) begin
      r2_vld_q <= r1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vs_q      <= vs_d;
      r2_pos_q  <= r1_pos_q;
      r2_last_q <= r1_last_q;
    end
  end

  // step products
  logic                   r3_vld_q, r3_last_q;
  logic [VB-1:0]          r3_pos_q, r3_vel_q;
  logic signed [C+16:0]   dp_d [3];
  logic signed [C+16:0]   dp_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dp_d[k] = $signed({1'b0, ts_q}) * $signed(vs_q[k*C +: C]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r3_vld_q <= 1'b0;
    end else if (en) begin
      r3_vld_q <= r2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dp_q      <= dp_d;
      r3_pos_q  <= r2_pos_q;
      r3_vel_q  <= vs_q;
      r3_last_q <= r2_last_q;
    end
  end

  // integrate, wrap, saturate
  logic [VB-1:0] np_d;
  logic [VB-1:0] out_pos_q, out_vel_q;
  logic          out_last_q;

  always_comb begin
    logic signed [XW-1:0] x, hi, lo;
    for (int k = 0; k < 3; k++) begin
      hi = XW'($signed(bhi_q[k*C +: C]));
      lo = XW'($signed(blo_q[k*C +: C]));
      x  = XW'($signed(r3_pos_q[k*C +: C])) + ((XW'(dp_q[k]) + SHALF) >>> STEP_FRAC);
      if (x >= hi) begin
        x = x - hi;
      end else if (x <= lo) begin
        x = x + hi;
      end
      if (&x[XW-1:C-1] || ~|x[XW-1:C-1]) begin
        np_d[k*C +: C] = x[C-1:0];
      end else begin
        np_d[k*C +: C] = x[XW-1] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
      end
    end
    if (flat_q) begin
      np_d[2*C +: C] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= r3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_pos_q  <= np_d;
      out_vel_q  <= r3_vel_q;
      out_last_q <= r3_last_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_W'({out_vel_q, out_pos_q});
  assign m_axis_tlast  = out_last_q;

endmodule
`default_nettype wire

[rtl/bew_steer.sv]
// Steering stages: weighted steering sum, velocity update, squared length and clamp test.
// Uses bew_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bew_steer import bew_pkg::*; #(
  parameter int unsigned C = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         valid_i,
  input  wire logic [3*C-1:0]               position_i,
  input  wire logic [3*C-1:0]               velocity_i,
  input  wire logic [NUM_STEER*3*C-1:0]     steer_i,
  input  wire logic                         last_i,
  input  wire logic [NUM_STEER*WEIGHT_BITS-1:0] weights_i,
  input  wire logic [REG_BITS-1:0]          max_speed_i,
  output logic                              valid_o,
  output logic [3*C-1:0]                    position_o,
  output logic [3*(C+4)-1:0]                velocity_o,
  output logic                              last_o,
  output logic [2*(C+4)-1:0]                mag2_o,
  output logic                              clamp_o
);

  localparam int unsigned W  = C + 4;
  localparam int unsigned PW = C + WEIGHT_BITS + 1;
  localparam int unsigned AW = PW + 3;
  localparam int unsigned TW = AW + 1;
  localparam int unsigned MW = (2 * W > 2 * REG_BITS) ? 2 * W : 2 * REG_BITS;
  localparam logic signed [AW-1:0] RHALF = AW'(1) << (WEIGHT_FRAC - 1);

  logic                  vld_a_q, vld_b_q, vld_c_q, vld_d_q;
  logic signed [PW-1:0]  prod_d [3][NUM_STEER];
  logic signed [PW-1:0]  prod_q [3][NUM_STEER];
  logic [3*C-1:0]        pos_a_q, pos_b_q, pos_c_q, pos_d_q;
  logic [3*C-1:0]        vel_a_q;
  logic                  last_a_q, last_b_q, last_c_q, last_d_q;
  logic [3*W-1:0]        v_d, v_b_q, v_c_q, v_d_q;
  logic [2*W-2:0]        sq_d [3];
  logic [2*W-2:0]        sq_q [3];
  logic [2*REG_BITS-1:0] msq_d, msq_q;
  logic [2*W-1:0]        mag2_d, mag2_q;
  logic                  clamp_d, clamp_q;
  logic signed [AW-1:0]  acc;
  logic signed [AW-1:0]  rs;
  logic signed [TW-1:0]  vt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int s = 0; s < NUM_STEER; s++) begin
        prod_d[k][s] = $signed({1'b0, weights_i[s*WEIGHT_BITS +: WEIGHT_BITS]}) *
                       $signed(steer_i[(s*3+k)*C +: C]);
      end
    end
  end

  always_comb begin
    v_d = '0;
    acc = '0;
    rs  = '0;
    vt  = '0;
    for (int k = 0; k < 3; k++) begin
      acc = '0;
      for (int s = 0; s < NUM_STEER; s++) begin
        acc = acc + AW'(prod_q[k][s]);
      end
      rs = (acc + RHALF) >>> WEIGHT_FRAC;
      vt = TW'($signed(vel_a_q[k*C +: C])) + TW'(rs);
      if (&vt[TW-1:W-1] || ~|vt[TW-1:W-1]) begin
        v_d[k*W +: W] = vt[W-1:0];
      end else begin
        v_d[k*W +: W] = vt[TW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end
    end
  end

  always_comb begin
    logic signed [2*W-1:0] sq;
    for (int k = 0; k < 3; k++) begin
      sq = $signed(v_b_q[k*W +: W]) * $signed(v_b_q[k*W +: W]);
      sq_d[k] = sq[2*W-2:0];
    end
    msq_d = max_speed_i * max_speed_i;
  end

  assign mag2_d  = (2*W)'(sq_q[0]) + (2*W)'(sq_q[1]) + (2*W)'(sq_q[2]);
  assign clamp_d = MW'(mag2_d) > MW'(msq_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
      vld_d_q <= 1'b0;
    end else if (en_i) begin
      vld_a_q <= valid_i;
      vld_b_q <= vld_a_q;
      vld_c_q <= vld_b_q;
      vld_d_q <= vld_c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q   <= prod_d;
      pos_a_q  <= position_i;
      vel_a_q  <= velocity_i;
      last_a_q <= last_i;
      v_b_q    <= v_d;
      pos_b_q  <= pos_a_q;
      last_b_q <= last_a_q;
      sq_q     <= sq_d;
      msq_q    <= msq_d;
      v_c_q    <= v_b_q;
      pos_c_q  <= pos_b_q;
      last_c_q <= last_b_q;
      mag2_q   <= mag2_d;
      clamp_q  <= clamp_d;
      v_d_q    <= v_c_q;
      pos_d_q  <= pos_c_q;
      last_d_q <= last_c_q;
    end
  end

  assign valid_o    = vld_d_q;
  assign position_o = pos_d_q;
  assign velocity_o = v_d_q;
  assign last_o     = last_d_q;
  assign mag2_o     = mag2_q;
  assign clamp_o    = clamp_q;

endmodule
`default_nettype wire

[rtl/bew_sqrt.sv]
// Pipelined floor square root, one root bit per stage, with sideband data carried along.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module bew_sqrt #(
  parameter int unsigned RW = 20,
  parameter int unsigned SW = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire logic [2*RW-1:0] rad_i,
  input  wire logic [SW-1:0] side_i,
  output logic               valid_o,
  output logic [RW-1:0]      root_o,
  output logic [SW-1:0]      side_o
);

  logic [2*RW:0]  x_q    [RW+1];
  logic [RW-1:0]  r_q    [RW+1];
  logic [SW-1:0]  side_q [RW+1];
  logic           vld_q  [RW+1];

  assign x_q[0]    = {1'b0, rad_i};
  assign r_q[0]    = '0;
  assign side_q[0] = side_i;
  assign vld_q[0]  = valid_i;

  for (genvar i = 0; i < RW; i++) begin : g_stage
    localparam int unsigned B = RW - 1 - i;
    logic [2*RW:0] trial;
    assign trial = ({{(RW+1){1'b0}}, r_q[i]} << (B + 1)) + ((2*RW+1)'(1) << (2 * B));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[i+1] <= side_q[i];
        if (x_q[i] >= trial) begin
          x_q[i+1] <= x_q[i] - trial;
          r_q[i+1] <= r_q[i] | (RW'(1) << B);
        end else begin
          x_q[i+1] <= x_q[i];
          r_q[i+1] <= r_q[i];
        end
      end
    end
  end

  assign valid_o = vld_q[RW];
  assign root_o  = r_q[RW];
  assign side_o  = side_q[RW];

endmodule
`default_nettype wire

[rtl/bew_div.sv]
// Pipelined restoring divider, three numerators over one shared divisor, one quotient bit
// per stage, with sideband data carried along. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module bew_div #(
  parameter int unsigned NW = 38,
  parameter int unsigned DW = 21,
  parameter int unsigned QW = 17,
  parameter int unsigned SW = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire logic [3*NW-1:0] num_i,
  input  wire logic [DW-1:0]   den_i,
  input  wire logic [SW-1:0]   side_i,
  output logic                 valid_o,
  output logic [3*QW-1:0]      quot_o,
  output logic [SW-1:0]        side_o
);

  logic [3*NW-1:0] rem_q  [QW+1];
  logic [3*QW-1:0] quo_q  [QW+1];
  logic [DW-1:0]   den_q  [QW+1];
  logic [SW-1:0]   side_q [QW+1];
  logic            vld_q  [QW+1];

  assign rem_q[0]  = num_i;
  assign quo_q[0]  = '0;
  assign den_q[0]  = den_i;
  assign side_q[0] = side_i;
  assign vld_q[0]  = valid_i;

  for (genvar i = 0; i < QW; i++) begin : g_stage
    localparam int unsigned B = QW - 1 - i;
    logic [NW:0]     dsh;
    logic [3*NW-1:0] rem_d;
    logic [3*QW-1:0] quo_d;
    assign dsh = {{(NW+1-DW){1'b0}}, den_q[i]} << B;

    always_comb begin
      rem_d = rem_q[i];
      quo_d = quo_q[i];
      for (int k = 0; k < 3; k++) begin
        if ({1'b0, rem_q[i][k*NW +: NW]} >= dsh) begin
          rem_d[k*NW +: NW] = rem_q[i][k*NW +: NW] - dsh[NW-1:0];
          quo_d[k*QW + B]   = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i+1]  <= rem_d;
        quo_q[i+1]  <= quo_d;
        den_q[i+1]  <= den_q[i];
        side_q[i+1] <= side_q[i];
      end
    end
  end

  assign valid_o = vld_q[QW];
  assign quot_o  = quo_q[QW];
  assign side_o  = side_q[QW];

endmodule
`default_nettype wire
